>>> rtl/core/float_predictor_row_decode_core_assert.svh
// assertion macros shared by the row decode core
`ifndef FLOAT_PREDICTOR_ROW_DECODE_CORE_ASSERT_SVH
`define FLOAT_PREDICTOR_ROW_DECODE_CORE_ASSERT_SVH

// condition holds in the same cycle
`define FPRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fprd check failed");

// condition holds in the cycle after the antecedent
`define FPRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fprd check failed");

`endif

>>> rtl/core/fprd_pkg.sv
// ----------------------------------------------------------------------------
// fprd_pkg
// shared constants, types and float widening functions of the row decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fprd_pkg;

  localparam int MAX_TILE_WIDTH = 1024;
  localparam int COL_W          = $clog2(MAX_TILE_WIDTH);
  localparam int MAX_STRIDE     = 16;
  localparam int HIST_W         = $clog2(MAX_STRIDE);
  localparam int POS_W          = $clog2(4 * MAX_TILE_WIDTH);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BPS    = 3'd0,
    REG_STRIDE = 3'd1,
    REG_TW     = 3'd2,
    REG_OW     = 3'd3
  } cfg_reg_t;

  // effective configuration after clamping
  typedef struct packed {
    logic [2:0]  bps;
    logic [4:0]  stride;
    logic [10:0] tw;
    logic [10:0] ow;
  } cfg_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0]       byte_val;
    logic [1:0]       plane;
    logic [COL_W-1:0] col;
    logic             last_plane;
    logic             emit;
    logic             row_last;
  } item_t;

  // half (1-5-10) to binary32
  function automatic logic [31:0] widen_half(input logic [15:0] v);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] idx;
    logic [9:0] mn;
    logic [7:0] e32;
    s   = v[15];
    e   = v[14:10];
    m   = v[9:0];
    idx = '0;
    for (int k = 0; k < 10; k++) begin
      if (m[k]) idx = 4'(k);
    end
    mn  = m << (4'd10 - idx);
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      e32 = 8'd103 + {4'd0, idx};
      return {s, e32, mn, 13'd0};
    end else if (e == 5'h1f) begin
      return {s, 8'hff, m, 13'd0};
    end
    e32 = {3'd0, e} + 8'd112;
    return {s, e32, m, 13'd0};
  endfunction

  // 24-bit float (1-7-16) to binary32
  function automatic logic [31:0] widen_f24(input logic [23:0] v);
    logic        s;
    logic [6:0]  e;
    logic [15:0] m;
    logic [4:0]  idx;
    logic [15:0] mn;
    logic [7:0]  e32;
    s   = v[23];
    e   = v[22:16];
    m   = v[15:0];
    idx = '0;
    for (int k = 0; k < 16; k++) begin
      if (m[k]) idx = 5'(k);
    end
    mn  = m << (5'd16 - idx);
    if (e == 7'd0) begin
      if (m == 16'd0) return {s, 31'd0};
      e32 = 8'd49 + {3'd0, idx};
      return {s, e32, mn, 7'd0};
    end else if (e == 7'h7f) begin
      return {s, 8'hff, m, 7'd0};
    end
    e32 = {1'b0, e} + 8'd64;
    return {s, e32, m, 7'd0};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fprd_front.sv
// ----------------------------------------------------------------------------
// fprd_front
// undoes the byte delta and classifies each byte by plane and column
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fprd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fprd_pkg::cfg_t  cfg,
  input  wire logic            cfg_wr,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output fprd_pkg::item_t      q_item
);

  logic [fprd_pkg::POS_W-1:0]  pos;
  logic [1:0]                  plane;
  logic [fprd_pkg::COL_W-1:0]  col;
  logic [7:0]                  hist [fprd_pkg::MAX_STRIDE];

  logic [fprd_pkg::HIST_W-1:0] hist_idx;
  logic                        use_delta;
  logic [7:0]                  dec;
  logic                        last_plane;
  logic                        col_end;
  logic                        accept;

  // delta decode against the byte one stride back
  always_comb begin
    hist_idx   = pos[fprd_pkg::HIST_W-1:0] - cfg.stride[fprd_pkg::HIST_W-1:0];
    use_delta  = pos >= {{(fprd_pkg::POS_W-5){1'b0}}, cfg.stride};
    dec        = in_byte + (use_delta ? hist[hist_idx] : 8'd0);
    last_plane = ({1'b0, plane} + 3'd1) == cfg.bps;
    col_end    = {1'b0, col} == (cfg.tw - 11'd1);
  end

  // item toward the back, nothing taken during reset
  always_comb begin
    in_ready          = q_ready && !rst;
    accept            = in_valid && in_ready;
    q_valid           = in_valid && !rst;
    q_item.byte_val   = dec;
    q_item.plane      = plane;
    q_item.col        = col;
    q_item.last_plane = last_plane;
    q_item.emit       = last_plane && ({1'b0, col} < cfg.ow);
    q_item.row_last   = ({1'b0, col} + 11'd1) == cfg.ow;
  end

  // position within the row
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pos   <= '0;
      plane <= '0;
      col   <= '0;
    end else if (accept) begin
      if (col_end && last_plane) begin
        pos   <= '0;
        plane <= '0;
        col   <= '0;
      end else if (col_end) begin
        pos   <= pos + 1'b1;
        plane <= plane + 2'd1;
        col   <= '0;
      end else begin
        pos   <= pos + 1'b1;
        col   <= col + 1'b1;
      end
    end
  end

  // recent decoded bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[pos[fprd_pkg::HIST_W-1:0]] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fprd_queue.sv
// ----------------------------------------------------------------------------
// fprd_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fprd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire fprd_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output fprd_pkg::item_t      pop_item
);

  fprd_pkg::item_t             slots [fprd_pkg::QUEUE_DEPTH];
  logic [fprd_pkg::QPTR_W-1:0] wr_ptr;
  logic [fprd_pkg::QPTR_W-1:0] rd_ptr;
  logic [fprd_pkg::QPTR_W:0]   count;
  logic                        push;
  logic                        pop;

  // flags
  always_comb begin
    push_ready = count != (fprd_pkg::QPTR_W+1)'(fprd_pkg::QUEUE_DEPTH);
    pop_valid  = count != '0;
    pop_item   = slots[rd_ptr];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

>>> rtl/core/fprd_back.sv
// ----------------------------------------------------------------------------
// fprd_back
// keeps earlier planes in the row store, joins and widens the samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "float_predictor_row_decode_core_assert.svh"

module fprd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [2:0]      bps,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire fprd_pkg::item_t q_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          sample_bits,
  output logic [9:0]           sample_column,
  output logic                 last_of_row
);

  logic [7:0] mem0 [fprd_pkg::MAX_TILE_WIDTH];
  logic [7:0] mem1 [fprd_pkg::MAX_TILE_WIDTH];
  logic [7:0] mem2 [fprd_pkg::MAX_TILE_WIDTH];

  logic                       s1_valid;
  logic [7:0]                 s1_byte;
  logic [fprd_pkg::COL_W-1:0] s1_col;
  logic                       s1_last;
  logic [7:0]                 rd0;
  logic [7:0]                 rd1;
  logic [7:0]                 rd2;

  logic        s1_adv;
  logic        pop;
  logic        wr_en;
  logic [31:0] bits_next;

  // stage control
  always_comb begin
    s1_adv  = s1_valid && (!out_valid || out_ready);
    q_ready = !s1_valid || s1_adv;
    pop     = q_valid && q_ready;
    wr_en   = pop && !q_item.last_plane;
  end

  // plane store, one memory per stored plane
  always_ff @(posedge clk) begin
    if (wr_en && q_item.plane == 2'd0) mem0[q_item.col] <= q_item.byte_val;
    if (pop) rd0 <= mem0[q_item.col];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_item.plane == 2'd1) mem1[q_item.col] <= q_item.byte_val;
    if (pop) rd1 <= mem1[q_item.col];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_item.plane == 2'd2) mem2[q_item.col] <= q_item.byte_val;
    if (pop) rd2 <= mem2[q_item.col];
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_ready) begin
      s1_valid <= pop && q_item.last_plane && q_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_byte <= q_item.byte_val;
      s1_col  <= q_item.col;
      s1_last <= q_item.row_last;
    end
  end

  // join planes big-endian and widen half and 24-bit samples to binary32
  always_comb begin
    unique case (bps)
      3'd2:    bits_next = fprd_pkg::widen_half({rd0, s1_byte});
      3'd3:    bits_next = fprd_pkg::widen_f24({rd0, rd1, s1_byte});
      default: bits_next = {rd0, rd1, rd2, s1_byte};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sample_bits   <= bits_next;
      sample_column <= s1_col;
      last_of_row   <= s1_last;
    end
  end

  `FPRD_ASSERT_NEXT(a_emit_reaches_s1, pop && q_item.last_plane && q_item.emit, s1_valid)
  `FPRD_ASSERT_NEXT(a_s1_fills_out, s1_valid && !out_valid, out_valid)
  `FPRD_ASSERT_NEXT(a_out_drains, out_valid && out_ready && !s1_valid, !out_valid)

endmodule

`default_nettype wire

>>> rtl/core/float_predictor_row_decode_core.sv
// ----------------------------------------------------------------------------
// float_predictor_row_decode_core
// floating-point predictor row decoder: byte delta undo, plane join, widening
//
//   channel  signals                                        dir
//   in       in_valid in_ready in_byte                      byte in
//   out      out_valid out_ready sample_bits sample_column  sample out
//            last_of_row
//   cfg      cfg_valid cfg_ready cfg_index cfg_data         register write
//
// one byte per cycle sustained when nothing stalls; after its last byte is
// accepted, a sample is registered in the queue slot, the read stage and the
// output register before it is valid at the output
// the plane store read port sets the read stage; a four entry queue decouples
// front and back so either side can stall alone
// reset clears control only; the row store needs no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module float_predictor_row_decode_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      sample_bits,
  output logic [9:0]       sample_column,
  output logic             last_of_row,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  logic [2:0]  bps_raw;
  logic [4:0]  stride_raw;
  logic [10:0] tw_raw;
  logic [10:0] ow_raw;
  logic        cfg_wr;

  fprd_pkg::cfg_t  cfg;
  fprd_pkg::item_t f_item;
  fprd_pkg::item_t b_item;
  logic            f_valid;
  logic            f_ready;
  logic            b_valid;
  logic            b_ready;

  // register writes
  always_comb begin
    cfg_ready = !rst;
    unique case (fprd_pkg::cfg_reg_t'(cfg_index))
      fprd_pkg::REG_BPS, fprd_pkg::REG_STRIDE,
      fprd_pkg::REG_TW, fprd_pkg::REG_OW: cfg_wr = cfg_valid && cfg_ready;
      default:                            cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bps_raw    <= 3'd4;
      stride_raw <= 5'd1;
      tw_raw     <= 11'd1024;
      ow_raw     <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (fprd_pkg::cfg_reg_t'(cfg_index))
        fprd_pkg::REG_BPS:    bps_raw    <= cfg_data[2:0];
        fprd_pkg::REG_STRIDE: stride_raw <= cfg_data[4:0];
        fprd_pkg::REG_TW:     tw_raw     <= cfg_data;
        fprd_pkg::REG_OW:     ow_raw     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to supported ranges
  always_comb begin
    cfg.bps    = (bps_raw < 3'd2) ? 3'd2 : ((bps_raw > 3'd4) ? 3'd4 : bps_raw);
    cfg.stride = (stride_raw == 5'd0) ? 5'd1 :
                 ((stride_raw > 5'(fprd_pkg::MAX_STRIDE)) ?
                  5'(fprd_pkg::MAX_STRIDE) : stride_raw);
    cfg.tw     = (tw_raw == 11'd0) ? 11'd1 :
                 ((tw_raw > 11'(fprd_pkg::MAX_TILE_WIDTH)) ?
                  11'(fprd_pkg::MAX_TILE_WIDTH) : tw_raw);
    cfg.ow     = (ow_raw < cfg.tw) ? ow_raw : cfg.tw;
  end

  fprd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  fprd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  fprd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .bps           (cfg.bps),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_item        (b_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_bits   (sample_bits),
    .sample_column (sample_column),
    .last_of_row   (last_of_row)
  );

endmodule

`default_nettype wire
